>>> rtl/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
package mtep_pkg;

   localparam int BYTE_W     = 8;
   localparam int TIME_W     = 32;
   localparam int KIND_W     = 3;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = KIND_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - (TIME_W + 5 * BYTE_W + 1);

   localparam logic [BYTE_W-1:0] DATA_MASK    = 8'h7f;
   localparam logic [BYTE_W-1:0] HIGH_NIBBLE  = 8'hf0;
   localparam logic [BYTE_W-1:0] LOW_NIBBLE   = 8'h0f;
   localparam logic [BYTE_W-1:0] ST_SYSEX     = 8'hf0;
   localparam logic [BYTE_W-1:0] ST_SYSEX_END = 8'hf7;
   localparam logic [BYTE_W-1:0] ST_META      = 8'hff;
   localparam logic [BYTE_W-1:0] ST_CHAN_LO   = 8'h80;
   localparam logic [BYTE_W-1:0] ST_PROG      = 8'hc0;
   localparam logic [BYTE_W-1:0] ST_PRESS     = 8'hd0;

   typedef enum logic [3:0] {
      PH_START  = 4'd0,
      PH_DELTA  = 4'd1,
      PH_STATUS = 4'd2,
      PH_PARAM1 = 4'd3,
      PH_PARAM2 = 4'd4,
      PH_SYSEX  = 4'd5,
      PH_MTYPE  = 4'd6,
      PH_MLEN   = 4'd7,
      PH_MDATA  = 4'd8
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHANNEL    = 3'd0,
      KIND_SYSEX      = 3'd1,
      KIND_META_DATA  = 3'd2,
      KIND_META_EMPTY = 3'd3,
      KIND_ERROR      = 3'd4
   } result_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              track_start;
   } in_word_type;

   typedef struct packed {
      result_kind_type   result_kind;
      logic [TIME_W-1:0] time_stamp;
      logic [BYTE_W-1:0] status_value;
      logic [BYTE_W-1:0] param_first;
      logic [BYTE_W-1:0] param_second;
      logic [BYTE_W-1:0] meta_kind;
      logic [BYTE_W-1:0] payload_byte;
      logic              last_of_event;
      logic              running_flag;
   } result_type;

endpackage

>>> rtl/mtep_in_reg.sv
// Input register for request words, advanced when the parser step fires.
module mtep_in_reg
   import mtep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  in_word_type req_word,
   input  logic        advance,
   output logic        word_valid,
   output in_word_type word
);

   logic        valid_ff, valid_in;
   in_word_type word_ff;

   assign req_ready  = !valid_ff || advance;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         word_ff <= req_word;
      end
   end

endmodule

>>> rtl/mtep_core.sv
// Parser state registers and per-byte next-state and result logic.
module mtep_core
   import mtep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  in_word_type word,
   output logic        emit,
   output result_type  result
);

   phase_type         phase_ff, phase_in, ph;
   logic [TIME_W-1:0] delta_ff, delta_in;
   logic [TIME_W-1:0] abs_ff, abs_in;
   logic [TIME_W-1:0] mlen_ff, mlen_in;
   logic [TIME_W-1:0] mcount_ff, mcount_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [BYTE_W-1:0] cur_ff, cur_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic [BYTE_W-1:0] hmeta_ff, hmeta_in;
   logic              run_ff, run_in;
   logic              halt_ff, halt_in;
   logic [BYTE_W-1:0] d, st, up;
   logic              rs;
   result_type        res;

   always_comb begin
      d         = word.data_byte;
      phase_in  = phase_ff;
      delta_in  = delta_ff;
      abs_in    = abs_ff;
      mlen_in   = mlen_ff;
      mcount_in = mcount_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      held_in   = held_ff;
      hmeta_in  = hmeta_ff;
      run_in    = run_ff;
      halt_in   = halt_ff;
      if (word.track_start) begin
         phase_in  = PH_START;
         delta_in  = '0;
         abs_in    = '0;
         mlen_in   = '0;
         mcount_in = '0;
         prev_in   = '0;
         cur_in    = '0;
         held_in   = '0;
         hmeta_in  = '0;
         run_in    = 1'b0;
         halt_in   = 1'b0;
      end
      st   = d;
      up   = '0;
      rs   = 1'b0;
      emit = 1'b0;
      res  = '0;
      ph   = phase_in;
      if (!halt_in) begin
         if (ph == PH_START || ph > PH_MDATA) begin
            delta_in  = '0;
            mlen_in   = '0;
            mcount_in = '0;
            ph        = PH_DELTA;
         end
         unique case (ph)
            PH_DELTA: begin
               delta_in = {delta_in[TIME_W-8:0], d[6:0]};
               phase_in = d[7] ? PH_DELTA : PH_STATUS;
            end
            PH_STATUS: begin
               rs     = !d[7];
               st     = rs ? prev_in : d;
               run_in = !(d[7] && d == prev_in);
               abs_in = abs_in + delta_in;
               prev_in = st;
               cur_in  = st;
               up      = st & HIGH_NIBBLE;
               if (st >= ST_CHAN_LO && st < ST_SYSEX) begin
                  phase_in = PH_PARAM2;
                  if (rs) begin
                     held_in = d;
                     if (up == ST_PROG || up == ST_PRESS) begin
                        emit             = 1'b1;
                        res.result_kind  = KIND_CHANNEL;
                        res.status_value = st;
                        res.param_first  = d;
                        res.last_of_event = 1'b1;
                        phase_in         = PH_START;
                     end
                  end else begin
                     phase_in = PH_PARAM1;
                  end
               end else if (st == ST_SYSEX || st == ST_SYSEX_END) begin
                  emit             = 1'b1;
                  res.result_kind  = KIND_SYSEX;
                  res.status_value = st;
                  res.payload_byte = d;
                  phase_in         = PH_SYSEX;
                  if (rs && d == ST_SYSEX_END) begin
                     res.last_of_event = 1'b1;
                     phase_in          = PH_START;
                  end
               end else if (st == ST_META) begin
                  if (rs) begin
                     hmeta_in = d;
                     phase_in = PH_MLEN;
                  end else begin
                     phase_in = PH_MTYPE;
                  end
               end else begin
                  emit             = 1'b1;
                  res.result_kind  = KIND_ERROR;
                  res.status_value = st;
                  halt_in          = 1'b1;
                  phase_in         = PH_STATUS;
               end
            end
            PH_PARAM1: begin
               held_in = d;
               up      = cur_in & HIGH_NIBBLE;
               if (up == ST_PROG || up == ST_PRESS) begin
                  emit              = 1'b1;
                  res.result_kind   = KIND_CHANNEL;
                  res.status_value  = cur_in;
                  res.param_first   = d;
                  res.last_of_event = 1'b1;
                  phase_in          = PH_START;
               end else begin
                  phase_in = PH_PARAM2;
               end
            end
            PH_PARAM2: begin
               emit              = 1'b1;
               res.result_kind   = KIND_CHANNEL;
               res.status_value  = cur_in;
               res.param_first   = held_in;
               res.param_second  = d;
               res.last_of_event = 1'b1;
               phase_in          = PH_START;
            end
            PH_SYSEX: begin
               emit              = 1'b1;
               res.result_kind   = KIND_SYSEX;
               res.status_value  = cur_in;
               res.payload_byte  = d;
               res.last_of_event = (d == ST_SYSEX_END);
               phase_in          = (d == ST_SYSEX_END) ? PH_START : PH_SYSEX;
            end
            PH_MTYPE: begin
               hmeta_in = d;
               phase_in = PH_MLEN;
            end
            PH_MLEN: begin
               mlen_in = {mlen_in[TIME_W-8:0], d[6:0]};
               if (d[7]) begin
                  phase_in = PH_MLEN;
               end else if (mlen_in == '0) begin
                  emit              = 1'b1;
                  res.result_kind   = KIND_META_EMPTY;
                  res.status_value  = cur_in;
                  res.meta_kind     = hmeta_in;
                  res.last_of_event = 1'b1;
                  phase_in          = PH_START;
               end else begin
                  phase_in = PH_MDATA;
               end
            end
            PH_MDATA: begin
               mcount_in         = mcount_in + 32'd1;
               emit              = 1'b1;
               res.result_kind   = KIND_META_DATA;
               res.status_value  = cur_in;
               res.meta_kind     = hmeta_in;
               res.payload_byte  = d;
               res.last_of_event = (mcount_in == mlen_in);
               phase_in          = (mcount_in == mlen_in) ? PH_START : PH_MDATA;
            end
            default: begin
               phase_in = PH_START;
            end
         endcase
      end
      res.time_stamp   = abs_in;
      res.running_flag = run_in;
      result           = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         delta_ff  <= '0;
         abs_ff    <= '0;
         mlen_ff   <= '0;
         mcount_ff <= '0;
         prev_ff   <= '0;
         cur_ff    <= '0;
         held_ff   <= '0;
         hmeta_ff  <= '0;
         run_ff    <= 1'b0;
         halt_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         delta_ff  <= delta_in;
         abs_ff    <= abs_in;
         mlen_ff   <= mlen_in;
         mcount_ff <= mcount_in;
         prev_ff   <= prev_in;
         cur_ff    <= cur_in;
         held_ff   <= held_in;
         hmeta_ff  <= hmeta_in;
         run_ff    <= run_in;
         halt_ff   <= halt_in;
      end
   end

endmodule

>>> rtl/mtep_out_reg.sv
// Result register holding one word until the receiver takes it.
module mtep_out_reg
   import mtep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_word,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_word
);

   logic       valid_ff, valid_in;
   result_type word_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

endmodule

>>> rtl/midi_track_event_parser_unit.sv
// Top level of the MIDI track event parser.
//
// Usage: track chunk body bytes enter on the req_ channel, one byte per word,
// with req_tuser[0] high on the first byte of each track (clears time stamp,
// running status, parser phase and the halt after a format error).
// Each accepted byte gives zero or one word on the rsp_ channel: a complete
// channel event, one sysex or meta payload byte, an empty meta event, or a
// format error. After an error no words come out until a track start byte.
// A byte accepted from req_ is held in the input register, then parsed into
// the result register, whose word stays on rsp_ until the receiver takes it.
// Throughput: one byte per cycle while the receiver does not stall; the
// single parse step between the input and result registers sets it.
// When the receiver stalls, the result register holds its word and every
// byte waits in the input register, whether it gives a word or not;
// req_tready drops once the input register is full too.
// Reset (synchronous, active high) empties both registers and clears the
// parser state to the start of an event.
module midi_track_event_parser_unit
   import mtep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] data_byte
   input  logic [REQ_USER_W-1:0] req_tuser,  // [0] track_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] time_stamp, [39:32] status_value, [47:40] param_first,
   // [55:48] param_second, [63:56] meta_kind, [71:64] payload_byte,
   // [72] running_flag, [79:73] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,  // [2:0] result_kind
   output logic                  rsp_tlast   // last_of_event
);

   in_word_type req_word, word;
   logic        word_valid, out_free, emit, step;
   result_type  result, rsp_word;

   assign req_word.data_byte   = req_tdata[BYTE_W-1:0];
   assign req_word.track_start = req_tuser[0];

   assign step = word_valid && out_free;

   mtep_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_word   (req_word),
      .advance    (out_free),
      .word_valid (word_valid),
      .word       (word)
   );

   mtep_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (word),
      .emit   (emit),
      .result (result)
   );

   mtep_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step && emit),
      .load_word (result),
      .free      (out_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_word  (rsp_word)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_word.running_flag, rsp_word.payload_byte,
                       rsp_word.meta_kind, rsp_word.param_second, rsp_word.param_first,
                       rsp_word.status_value, rsp_word.time_stamp};
   assign rsp_tuser = rsp_word.result_kind;
   assign rsp_tlast = rsp_word.last_of_event;

endmodule

>>> verif/midi_track_event_parser_unit_tb.sv
// Self-checking testbench for the MIDI track event parser: directed and random track bytes.
`timescale 1ns / 100ps

module midi_track_event_parser_unit_tb;
   import mtep_pkg::*;

   localparam int RANDOM_BYTES = 1550;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 8;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   midi_track_event_parser_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // parser shadow state
   phase_type   parse_ph;
   logic [31:0] delta_sum;
   logic [31:0] tick_now;
   logic [31:0] meta_len;
   logic [31:0] meta_seen;
   logic [7:0]  last_status;
   logic [7:0]  event_status;
   logic [7:0]  first_param;
   logic [7:0]  meta_type;
   logic        running_on;
   logic        halted_now;

   result_type  parsed_events[$];
   int          mismatches        = 0;
   int          bytes_parsed      = 0;
   logic        track_start_next  = 1'b0;
   logic        tx_gaps           = 1'b1;
   logic        rx_stalls         = 1'b1;
   logic        hold_pending      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void clear_parser();
      parse_ph     = PH_START;
      delta_sum    = '0;
      tick_now     = '0;
      meta_len     = '0;
      meta_seen    = '0;
      last_status  = '0;
      event_status = '0;
      first_param  = '0;
      meta_type    = '0;
      running_on   = 1'b0;
      halted_now   = 1'b0;
   endfunction

   function automatic void add_event(result_kind_type k, logic [7:0] st, logic [7:0] p1,
                                     logic [7:0] p2, logic [7:0] mk, logic [7:0] pl,
                                     logic last);
      result_type r;
      r.result_kind   = k;
      r.time_stamp    = tick_now;
      r.status_value  = st;
      r.param_first   = p1;
      r.param_second  = p2;
      r.meta_kind     = mk;
      r.payload_byte  = pl;
      r.last_of_event = last;
      r.running_flag  = running_on;
      parsed_events.insert(parsed_events.size(), r);
   endfunction

   // returns 1 when the byte was parsed, 0 when the parser is halted
   function automatic bit parse_track_byte(logic [7:0] d, logic ts);
      logic       again;
      logic [7:0] st;
      logic [7:0] upper;
      int         round;
      if (ts)
         clear_parser();
      if (halted_now)
         return 1'b0;
      again = 1'b1;
      for (round = 0; round < 2 && again; round++) begin
         again = 1'b0;
         if (parse_ph == PH_START || parse_ph > PH_MDATA) begin
            delta_sum = '0;
            meta_len  = '0;
            meta_seen = '0;
            parse_ph  = PH_DELTA;
         end
         case (parse_ph)
            PH_DELTA: begin
               delta_sum = (delta_sum << 7) + 32'(d & DATA_MASK);
               if (!d[7])
                  parse_ph = PH_STATUS;
            end
            PH_STATUS: begin
               st = d;
               running_on = 1'b1;
               if (!d[7]) begin
                  again = 1'b1;
                  st = last_status;
               end else if (st == last_status) begin
                  running_on = 1'b0;
               end
               tick_now     = tick_now + delta_sum;
               last_status  = st;
               event_status = st;
               if (st >= ST_CHAN_LO && st < ST_SYSEX) begin
                  parse_ph = PH_PARAM1;
               end else if (st == ST_SYSEX || st == ST_SYSEX_END) begin
                  if (!again)
                     add_event(KIND_SYSEX, st, '0, '0, '0, d, 1'b0);
                  parse_ph = PH_SYSEX;
               end else if (st == ST_META) begin
                  parse_ph = PH_MTYPE;
               end else begin
                  add_event(KIND_ERROR, st, '0, '0, '0, '0, 1'b0);
                  halted_now = 1'b1;
                  return 1'b1;
               end
            end
            PH_PARAM1: begin
               upper = event_status & HIGH_NIBBLE;
               first_param = d;
               if (upper == ST_PROG || upper == ST_PRESS) begin
                  add_event(KIND_CHANNEL, event_status, d, '0, '0, '0, 1'b1);
                  parse_ph = PH_START;
               end else begin
                  parse_ph = PH_PARAM2;
               end
            end
            PH_PARAM2: begin
               add_event(KIND_CHANNEL, event_status, first_param, d, '0, '0, 1'b1);
               parse_ph = PH_START;
            end
            PH_SYSEX: begin
               add_event(KIND_SYSEX, event_status, '0, '0, '0, d, d == ST_SYSEX_END);
               if (d == ST_SYSEX_END)
                  parse_ph = PH_START;
            end
            PH_MTYPE: begin
               meta_type = d;
               parse_ph  = PH_MLEN;
            end
            PH_MLEN: begin
               meta_len = (meta_len << 7) + 32'(d & DATA_MASK);
               if (!d[7]) begin
                  if (meta_len == 0) begin
                     add_event(KIND_META_EMPTY, event_status, '0, '0, meta_type, '0, 1'b1);
                     parse_ph = PH_START;
                  end else begin
                     parse_ph = PH_MDATA;
                  end
               end
            end
            PH_MDATA: begin
               meta_seen = meta_seen + 1;
               add_event(KIND_META_DATA, event_status, '0, '0, meta_type, d,
                         meta_seen == meta_len);
               if (meta_seen == meta_len)
                  parse_ph = PH_START;
            end
            default: parse_ph = PH_START;
         endcase
      end
      return 1'b1;
   endfunction

   // mostly no pause, some short, a few long
   function automatic int pick_pause(logic enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   task automatic check_word();
      result_type want;
      if (parsed_events.size() == 0) begin
         report_mismatch($sformatf("word with nothing expected, kind %0d status %h",
                                   rsp_tuser, rsp_tdata[39:32]));
         return;
      end
      want = parsed_events.pop_front();
      check_field("result_kind", 32'(rsp_tuser), 32'(want.result_kind));
      check_field("time_stamp", rsp_tdata[31:0], want.time_stamp);
      check_field("status_value", 32'(rsp_tdata[39:32]), 32'(want.status_value));
      check_field("param_first", 32'(rsp_tdata[47:40]), 32'(want.param_first));
      check_field("param_second", 32'(rsp_tdata[55:48]), 32'(want.param_second));
      check_field("meta_kind", 32'(rsp_tdata[63:56]), 32'(want.meta_kind));
      check_field("payload_byte", 32'(rsp_tdata[71:64]), 32'(want.payload_byte));
      check_field("running_flag", 32'(rsp_tdata[72]), 32'(want.running_flag));
      check_field("tdata pad", 32'(rsp_tdata[79:73]), '0);
      check_field("last_of_event", 32'(rsp_tlast), 32'(want.last_of_event));
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            check_word();
      end
   end

   // result side back-pressure
   initial begin : rx_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = pick_pause(rx_stalls);
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_pause(tx_gaps);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= track_start_next;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (parse_track_byte(b, track_start_next))
         bytes_parsed++;
      track_start_next = 1'b0;
   endtask

   task automatic begin_track();
      track_start_next = 1'b1;
   endtask

   // variable-length number, 7 bits per byte, most significant group first
   task automatic send_number(input logic [48:0] v, input int groups);
      int g;
      for (g = groups - 1; g >= 0; g--)
         send_byte({g != 0, v[7*g +: 7]});
   endtask

   task automatic send_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         send_number('0, 1);
      else if (r < 75)
         send_number(49'($urandom_range(0, 127)), 1);
      else if (r < 92)
         send_number(49'($urandom), $urandom_range(2, 3));
      else
         send_number(49'({$urandom, $urandom}), $urandom_range(4, 6));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (parsed_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_channel(input logic use_running);
      logic [7:0] st;
      logic [7:0] upper;
      send_delta();
      if (use_running) begin
         st = last_status;
         send_byte(8'($urandom_range(0, 127)));
      end else begin
         st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
         if (last_status >= ST_CHAN_LO && last_status < ST_SYSEX && $urandom_range(0, 3) == 0)
            st = last_status;
         send_byte(st);
         send_byte(8'($urandom_range(0, 255)));
      end
      upper = st & HIGH_NIBBLE;
      if (upper != ST_PROG && upper != ST_PRESS)
         send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_sysex_body(input int n);
      logic [7:0] b;
      repeat (n) begin
         do b = 8'($urandom_range(0, 255)); while (b == ST_SYSEX_END);
         send_byte(b);
      end
      send_byte(ST_SYSEX_END);
   endtask

   task automatic send_meta(input logic [7:0] kind, input int len, input logic wide);
      logic [48:0] v;
      v = '0;
      v[31:0] = len;
      send_delta();
      send_byte(ST_META);
      send_byte(kind);
      if (wide) begin
         v[34:32] = 3'($urandom_range(1, 7));
         send_number(v, 5);
      end else begin
         send_number(v, len < 128 ? $urandom_range(1, 2) : 2);
      end
      repeat (len) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic random_event();
      int         r;
      int         len;
      logic [7:0] bad;
      logic       chan_prev;
      logic       sysex_prev;
      r          = $urandom_range(0, 99);
      chan_prev  = last_status >= ST_CHAN_LO && last_status < ST_SYSEX;
      sysex_prev = last_status == ST_SYSEX || last_status == ST_SYSEX_END;
      if (r < 42) begin
         send_channel(chan_prev && $urandom_range(0, 2) == 0);
      end else if (r < 54 || (r < 60 && !sysex_prev)) begin
         send_delta();
         send_byte($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_END);
         send_sysex_body($urandom_range(0, 6));
      end else if (r < 60) begin
         // running status continues the sysex payload
         send_delta();
         send_byte(8'($urandom_range(0, 127)));
         send_sysex_body($urandom_range(0, 5));
      end else if (r < 80) begin
         len = $urandom_range(0, 99) < 20 ? 0 :
               ($urandom_range(0, 19) == 0 ? $urandom_range(7, 40) : $urandom_range(1, 6));
         send_meta(8'($urandom_range(0, 255)), len, 1'b0);
      end else if (r < 85) begin
         send_meta(8'($urandom_range(0, 255)), $urandom_range(0, 4), 1'b1);
      end else if (r < 93) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 96) begin
         do bad = 8'($urandom_range(8'hf1, 8'hfe)); while (bad == ST_SYSEX_END);
         send_delta();
         send_byte(bad);
      end else begin
         // data byte where a status belongs, whatever came before
         send_delta();
         send_byte(8'($urandom_range(0, 127)));
      end
   endtask

   task automatic test_channel_events();
      begin_track();
      send_byte(8'h00); send_byte(8'h90); send_byte(8'h3c); send_byte(8'h7f);
      send_number(49'd128, 2); send_byte(8'hc5); send_byte(8'hff);
      send_byte(8'h00); send_byte(8'h12);
      send_byte(8'h00); send_byte(8'hc5); send_byte(8'h00);
      send_byte(8'h05); send_byte(8'hd3); send_byte(8'h80);
      send_byte(8'h7f); send_byte(8'hef); send_byte(8'h00); send_byte(8'hff);
      wait_drained();
   endtask

   task automatic test_sysex_and_meta();
      begin_track();
      send_byte(8'h00); send_byte(ST_SYSEX); send_byte(8'h01); send_byte(ST_SYSEX_END);
      send_byte(8'h00); send_byte(8'h05); send_byte(ST_SYSEX_END);
      send_byte(8'h00); send_byte(ST_SYSEX_END); send_byte(8'h7f); send_byte(ST_SYSEX_END);
      send_byte(8'h00); send_byte(ST_META); send_byte(8'h2f); send_byte(8'h00);
      send_byte(8'h7f); send_byte(ST_META); send_byte(8'h51); send_byte(8'h02);
      send_byte(8'haa); send_byte(ST_SYSEX_END);
      wait_drained();
   endtask

   task automatic test_format_errors();
      begin_track();
      send_byte(8'h00); send_byte(8'h40);
      send_byte(8'h90);
      begin_track();
      send_byte(8'h83); send_byte(8'h00); send_byte(8'hf1);
      send_byte(8'h00);
      begin_track();
      send_byte(8'h00); send_byte(8'h90); send_byte(8'h3c);
      begin_track();
      send_number({49{1'b1}}, 5);
      send_byte(ST_META); send_byte(8'h01); send_number(49'h1_0000_0002, 5);
      send_byte(8'ha1); send_byte(8'hb2);
      send_byte(8'h00); send_byte(ST_META); send_byte(8'h03); send_number(49'h1_0000_0000, 5);
      send_byte(8'h00); send_byte(8'hfe);
      wait_drained();
   endtask

   task automatic test_result_backpressure();
      tx_gaps      = 1'b0;
      hold_pending = 1'b1;
      begin_track();
      send_byte(8'h00);
      send_byte(ST_SYSEX);
      repeat (48) send_byte(8'($urandom_range(0, 127)));
      send_byte(ST_SYSEX_END);
      wait_drained();
      tx_gaps = 1'b1;
   endtask

   task automatic test_random_tracks();
      int count;
      int k;
      bytes_parsed = 0;
      while (bytes_parsed < RANDOM_BYTES) begin
         tx_gaps   = 1'($urandom_range(0, 1));
         rx_stalls = 1'($urandom_range(0, 1));
         begin_track();
         count = $urandom_range(2, 30);
         for (k = 0; k < count && !halted_now; k++)
            random_event();
         if (halted_now)
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
      end
      wait_drained();
   endtask

   initial begin
      clear_parser();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_channel_events();
      test_sysex_and_meta();
      test_format_errors();
      test_result_backpressure();
      test_random_tracks();
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
rtl/mtep_pkg.sv
rtl/mtep_in_reg.sv
rtl/mtep_core.sv
rtl/mtep_out_reg.sv
rtl/midi_track_event_parser_unit.sv
verif/midi_track_event_parser_unit_tb.sv
